// ===== sv/itoa_pkg.sv =====
// Shared types, constants and the digit-to-character function of the radix ASCII converter.
package itoa_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int RADIX_WIDTH = 5;
   localparam int CHAR_WIDTH = 8;
   localparam int DIGIT_WIDTH = 4;

   // The divider retires this many quotient bits per cycle.
   localparam int STEP_BITS = 8;
   localparam int STEP_COUNT = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int PAD_WIDTH = STEP_COUNT * STEP_BITS;
   localparam int STEP_CNT_WIDTH = (STEP_COUNT > 1) ? $clog2(STEP_COUNT) : 1;

   // Digit stack: one entry per possible digit.
   localparam int STACK_DEPTH = VALUE_WIDTH;
   localparam int STACK_ADDR_WIDTH = $clog2(STACK_DEPTH);
   localparam int DIGIT_CNT_WIDTH = $clog2(STACK_DEPTH + 1);

   localparam logic [RADIX_WIDTH-1:0] MIN_RADIX = 5'd2;
   localparam logic [RADIX_WIDTH-1:0] MAX_RADIX = 5'd16;
   localparam logic [RADIX_WIDTH-1:0] DECIMAL_RADIX = 5'd10;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_TEN = 4'd10;

   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 8'd48;
   localparam logic [CHAR_WIDTH-1:0] CHAR_LOWER_A = 8'd97;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'd45;
   localparam logic [CHAR_WIDTH-1:0] CHAR_NULL = 8'd0;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] number;
      logic [RADIX_WIDTH-1:0]        radix;
   } itoa_req_type;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] ascii_char;
      logic                  last_char;
      logic                  bad_radix;
   } itoa_rsp_type;

   typedef struct packed {
      logic                   start;
      logic [VALUE_WIDTH-1:0] dividend;
      logic [RADIX_WIDTH-1:0] divisor;
   } itoa_div_cmd_type;

   typedef struct packed {
      logic                   done;
      logic [VALUE_WIDTH-1:0] quotient;
      logic [DIGIT_WIDTH-1:0] remainder;
   } itoa_div_status_type;

   function automatic logic [CHAR_WIDTH-1:0] digit_to_char(input logic [DIGIT_WIDTH-1:0] digit);
      logic [CHAR_WIDTH-1:0] result;
      if (digit >= DIGIT_TEN) begin
         result = CHAR_LOWER_A + {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, digit - DIGIT_TEN};
      end else begin
         result = CHAR_ZERO + {{(CHAR_WIDTH-DIGIT_WIDTH){1'b0}}, digit};
      end
      return result;
   endfunction

endpackage

// ===== sv/itoa_divider.sv =====
// Iterative divider of the magnitude by the radix, several quotient bits per cycle.
module itoa_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  itoa_pkg::itoa_div_cmd_type    div_cmd,
   output itoa_pkg::itoa_div_status_type div_status
);
   import itoa_pkg::*;

   logic [PAD_WIDTH-1:0]      shift_ff, shift_in;
   logic [DIGIT_WIDTH-1:0]    rem_ff, rem_in;
   logic [RADIX_WIDTH-1:0]    divisor_ff, divisor_in;
   logic [STEP_CNT_WIDTH-1:0] step_ff, step_in;
   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;

   // Long division of the top window by a base of at most 16: the running
   // remainder stays below the base, so each bit is a 5-bit compare and subtract.
   always_comb begin
      logic [DIGIT_WIDTH-1:0] rem;
      logic [RADIX_WIDTH-1:0] trial;
      logic [STEP_BITS-1:0]   window;
      logic [STEP_BITS-1:0]   qbits;
      rem = rem_ff;
      window = shift_ff[PAD_WIDTH-1 -: STEP_BITS];
      qbits = '0;
      for (int i = STEP_BITS - 1; i >= 0; i--) begin
         trial = {rem, window[i]};
         if (trial >= divisor_ff) begin
            trial = trial - divisor_ff;
            qbits[i] = 1'b1;
         end
         rem = trial[DIGIT_WIDTH-1:0];
      end

      shift_in = shift_ff;
      rem_in = rem_ff;
      divisor_in = divisor_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_cmd.start) begin
         shift_in = PAD_WIDTH'(div_cmd.dividend);
         rem_in = '0;
         divisor_in = div_cmd.divisor;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[PAD_WIDTH-STEP_BITS-1:0], qbits};
         rem_in = rem;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_CNT_WIDTH'(STEP_COUNT - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      shift_ff <= shift_in;
      rem_ff <= rem_in;
      divisor_ff <= divisor_in;
      step_ff <= step_in;
   end

   assign div_status.done = done_ff;
   assign div_status.quotient = shift_ff[VALUE_WIDTH-1:0];
   assign div_status.remainder = rem_ff;

endmodule

// ===== sv/itoa_digit_stack.sv =====
// Digit store: digits are written least significant first and read back in reverse.
module itoa_digit_stack (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [itoa_pkg::STACK_ADDR_WIDTH-1:0] wr_addr,
   input  logic [itoa_pkg::DIGIT_WIDTH-1:0]      wr_digit,
   input  logic                                  rd_en,
   input  logic [itoa_pkg::STACK_ADDR_WIDTH-1:0] rd_addr,
   output logic [itoa_pkg::DIGIT_WIDTH-1:0]      rd_digit
);
   import itoa_pkg::*;

   logic [DIGIT_WIDTH-1:0] mem [STACK_DEPTH];
   logic [DIGIT_WIDTH-1:0] rd_digit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_digit;
      end
      if (rd_en) begin
         rd_digit_ff <= mem[rd_addr];
      end
   end

   assign rd_digit = rd_digit_ff;

endmodule

// ===== sv/integer_to_radix_ascii_unit.sv =====
// Top level of the signed integer to radix ASCII converter.
// A radix outside 2..16 gives its single error word in the cycle after start. Otherwise
// each digit takes one pass of the divider (steps of 8 quotient bits, then a hand-off),
// then a '-' word goes out for negative decimal values, then one digit word per cycle.
// Busy stays high for the whole conversion; the last word leaves as busy falls.
// The receiver cannot stall. Synchronous reset idles the sequencer.
module integer_to_radix_ascii_unit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  itoa_pkg::itoa_req_type req_item,
   output logic                   rsp_strobe,
   output itoa_pkg::itoa_rsp_type rsp_item
);
   import itoa_pkg::*;

   // Sequencer states. DIVIDE peels one digit per divider pass and pushes it
   // onto the digit stack; SIGN sends the minus word; EMIT pops one digit per
   // cycle; DRAIN lets the last read leave the stack's output register.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT,
      ST_DRAIN
   } state_type;

   state_type                   state_ff, state_in;
   logic [DIGIT_CNT_WIDTH-1:0]  count_ff, count_in;
   logic [STACK_ADDR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RADIX_WIDTH-1:0]      radix_ff, radix_in;
   logic                        sign_ff, sign_in;
   logic                        pend_valid_ff, pend_valid_in;
   logic                        pend_last_ff, pend_last_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   itoa_rsp_type                rsp_item_ff, rsp_item_in;

   itoa_div_cmd_type            div_cmd;
   itoa_div_status_type         div_status;

   logic                        stk_wr_en;
   logic                        stk_rd_en;
   logic [DIGIT_WIDTH-1:0]      stk_rd_digit;

   logic                        radix_ok;
   logic                        number_neg;
   logic [VALUE_WIDTH-1:0]      number_bits;
   logic [VALUE_WIDTH-1:0]      magnitude;

   // The magnitude is formed as an unsigned two's complement negation, so the
   // most negative value becomes exactly 2^(VALUE_WIDTH-1) without overflow.
   always_comb begin
      radix_ok = req_item.radix inside {[MIN_RADIX:MAX_RADIX]};
      number_bits = req_item.number;
      number_neg = number_bits[VALUE_WIDTH-1];
      magnitude = number_neg ? (~number_bits + 1'b1) : number_bits;
   end

   itoa_divider u_divider (
      .clock      (clock),
      .reset      (reset),
      .div_cmd    (div_cmd),
      .div_status (div_status)
   );

   itoa_digit_stack u_digit_stack (
      .clock    (clock),
      .wr_en    (stk_wr_en),
      .wr_addr  (count_ff[STACK_ADDR_WIDTH-1:0]),
      .wr_digit (div_status.remainder),
      .rd_en    (stk_rd_en),
      .rd_addr  (rd_ptr_ff),
      .rd_digit (stk_rd_digit)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      rd_ptr_in = rd_ptr_ff;
      radix_in = radix_ff;
      sign_in = sign_ff;
      pend_valid_in = 1'b0;
      pend_last_in = pend_last_ff;
      rsp_valid_in = 1'b0;
      rsp_item_in = rsp_item_ff;
      div_cmd.start = 1'b0;
      div_cmd.dividend = div_status.quotient;
      div_cmd.divisor = radix_ff;
      stk_wr_en = 1'b0;
      stk_rd_en = 1'b0;

      // A digit read from the stack in the previous cycle becomes a word now.
      if (pend_valid_ff) begin
         rsp_valid_in = 1'b1;
         rsp_item_in.ascii_char = digit_to_char(stk_rd_digit);
         rsp_item_in.last_char = pend_last_ff;
         rsp_item_in.bad_radix = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (radix_ok) begin
                  radix_in = req_item.radix;
                  sign_in = number_neg && (req_item.radix == DECIMAL_RADIX);
                  count_in = '0;
                  div_cmd.start = 1'b1;
                  div_cmd.dividend = magnitude;
                  div_cmd.divisor = req_item.radix;
                  state_in = ST_DIVIDE;
               end else begin
                  // An unusable base answers with one flagged word and no digits.
                  rsp_valid_in = 1'b1;
                  rsp_item_in.ascii_char = CHAR_NULL;
                  rsp_item_in.last_char = 1'b1;
                  rsp_item_in.bad_radix = 1'b1;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_status.done) begin
               stk_wr_en = 1'b1;
               count_in = count_ff + 1'b1;
               if (div_status.quotient == '0) begin
                  // The digit just pushed is the most significant one.
                  rd_ptr_in = count_ff[STACK_ADDR_WIDTH-1:0];
                  state_in = sign_ff ? ST_SIGN : ST_EMIT;
               end else begin
                  div_cmd.start = 1'b1;
               end
            end
         end
         ST_SIGN: begin
            rsp_valid_in = 1'b1;
            rsp_item_in.ascii_char = CHAR_MINUS;
            rsp_item_in.last_char = 1'b0;
            rsp_item_in.bad_radix = 1'b0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            stk_rd_en = 1'b1;
            pend_valid_in = 1'b1;
            pend_last_in = (rd_ptr_ff == '0);
            if (rd_ptr_ff == '0) begin
               state_in = ST_DRAIN;
            end else begin
               rd_ptr_in = rd_ptr_ff - 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      count_ff <= count_in;
      rd_ptr_ff <= rd_ptr_in;
      radix_ff <= radix_in;
      sign_ff <= sign_in;
      pend_last_ff <= pend_last_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item = rsp_item_ff;

endmodule

// ===== sv/itoa_checker.sv =====
// Port-level checker of the radix ASCII converter and its bind to the top level.
module itoa_port_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input itoa_pkg::itoa_req_type req_item,
   input logic                   rsp_strobe,
   input itoa_pkg::itoa_rsp_type rsp_item
);
   import itoa_pkg::*;

   logic accept_good;
   logic accept_bad;

   assign accept_good = start && !busy && (req_item.radix >= MIN_RADIX)
                        && (req_item.radix <= MAX_RADIX);
   assign accept_bad = start && !busy && ((req_item.radix < MIN_RADIX)
                       || (req_item.radix > MAX_RADIX));

   // An error word is always alone and carries a null character.
   a_bad_word_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.bad_radix |-> rsp_item.last_char
      && (rsp_item.ascii_char == CHAR_NULL))
      else $error("error word without last flag or with a character");

   // A usable base keeps the block busy for the conversion.
   a_good_goes_busy: assert property (@(posedge clock) disable iff (reset)
      accept_good |=> busy && !rsp_strobe)
      else $error("conversion did not hold the block busy");

   // An unusable base answers in the next cycle and leaves the block free.
   a_bad_answers: assert property (@(posedge clock) disable iff (reset)
      accept_bad |=> rsp_strobe && rsp_item.bad_radix && !busy)
      else $error("bad base not answered at once");

   // Every other word is a digit, a lower-case hex letter or the minus sign.
   a_char_set: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.bad_radix |->
      ((rsp_item.ascii_char >= CHAR_ZERO) && (rsp_item.ascii_char <= 8'd57))
      || ((rsp_item.ascii_char >= CHAR_LOWER_A) && (rsp_item.ascii_char <= 8'd102))
      || (rsp_item.ascii_char == CHAR_MINUS))
      else $error("character outside the digit set");

   // The block becomes free exactly as the last word of a conversion goes out.
   a_free_on_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe && rsp_item.last_char && !rsp_item.bad_radix)
      else $error("block freed without its last word");

endmodule

bind integer_to_radix_ascii_unit itoa_port_checker u_itoa_port_checker (.*);

// ===== verif/itoa_checker.sv =====
// Checker that predicts the character words of the radix ASCII converter and compares them.
`timescale 1ns / 100ps

module itoa_checker (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  itoa_pkg::itoa_req_type req_item,
   input  logic                   rsp_strobe,
   input  itoa_pkg::itoa_rsp_type rsp_item,
   output int                     fail_count,
   output int                     pending_count,
   output int                     checked_count
);
   import itoa_pkg::*;

   localparam int REPORT_LIMIT = 10;

   itoa_rsp_type expected_chars [$];
   int           mismatch_total = 0;
   int           compared_total = 0;

   // Queues the characters of one conversion, most significant digit first.
   function automatic void predict_chars(input itoa_req_type word);
      logic [VALUE_WIDTH-1:0] magnitude;
      logic [VALUE_WIDTH-1:0] base;
      logic [VALUE_WIDTH-1:0] remainder;
      logic [CHAR_WIDTH-1:0]  digits [$];
      logic                   negative;
      itoa_rsp_type           rsp;
      if (word.radix < MIN_RADIX || word.radix > MAX_RADIX) begin
         rsp.ascii_char = CHAR_NULL;
         rsp.last_char = 1'b1;
         rsp.bad_radix = 1'b1;
         expected_chars.push_back(rsp);
         return;
      end
      negative = word.number[VALUE_WIDTH-1];
      // The two's complement of the most negative value is 2^31 read as unsigned.
      magnitude = negative ? (~word.number + 1'b1) : word.number;
      base = {{(VALUE_WIDTH-RADIX_WIDTH){1'b0}}, word.radix};
      do begin
         remainder = magnitude % base;
         if (remainder >= VALUE_WIDTH'(DIGIT_TEN)) begin
            digits.push_front(CHAR_LOWER_A + CHAR_WIDTH'(remainder - VALUE_WIDTH'(DIGIT_TEN)));
         end else begin
            digits.push_front(CHAR_ZERO + CHAR_WIDTH'(remainder));
         end
         magnitude = magnitude / base;
      end while (magnitude != '0);
      if (negative && word.radix == DECIMAL_RADIX) begin
         digits.push_front(CHAR_MINUS);
      end
      foreach (digits[i]) begin
         rsp.ascii_char = digits[i];
         rsp.last_char = (i == digits.size() - 1);
         rsp.bad_radix = 1'b0;
         expected_chars.push_back(rsp);
      end
   endfunction

   always @(posedge clock) begin
      itoa_rsp_type want;
      if (!reset) begin
         if (rsp_strobe) begin
            if (expected_chars.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= REPORT_LIMIT) begin
                  $display("%0t: unexpected character word char=%02h last=%0b bad=%0b",
                           $realtime, rsp_item.ascii_char, rsp_item.last_char,
                           rsp_item.bad_radix);
               end
            end else begin
               want = expected_chars.pop_front();
               compared_total++;
               if (rsp_item.ascii_char !== want.ascii_char ||
                   rsp_item.last_char !== want.last_char ||
                   rsp_item.bad_radix !== want.bad_radix) begin
                  mismatch_total++;
                  if (mismatch_total <= REPORT_LIMIT) begin
                     $display("%0t: character word differs: expected char=%02h last=%0b bad=%0b",
                              $realtime, want.ascii_char, want.last_char, want.bad_radix);
                     $display("%0t:                          actual   char=%02h last=%0b bad=%0b",
                              $realtime, rsp_item.ascii_char, rsp_item.last_char,
                              rsp_item.bad_radix);
                  end
               end
            end
         end
         if (start && !busy) begin
            predict_chars(req_item);
         end
      end
      fail_count <= mismatch_total;
      pending_count <= expected_chars.size();
      checked_count <= compared_total;
   end

endmodule

// ===== verif/tb_top.sv =====
// Testbench top that drives conversion words into the radix ASCII converter and gives the verdict.
`timescale 1ns / 100ps

module tb_top;
   import itoa_pkg::*;

   // The longest quiet stretch of a correct run is one 32-digit conversion in the
   // divider plus the longest sender gap, so this leaves a wide margin.
   localparam int WATCHDOG_LIMIT = 2000;
   // After the last expected word, wait as long as the slowest conversion takes.
   localparam int DRAIN_CYCLES = 6 * VALUE_WIDTH + 3;
   localparam int RANDOM_WORDS = 450;
   // The last words of the run are sent back to back.
   localparam int STEADY_TAIL = 60;
   localparam int PHASE_LENGTH = 40;

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   itoa_req_type req_item;
   logic         rsp_strobe;
   itoa_rsp_type rsp_item;

   int fail_count;
   int pending_count;
   int checked_count;
   int idle_cycles = 0;
   int words_sent = 0;
   int bad_radix_sent = 0;

   // Directed words: the extremes of both fields, zero, every sign case in decimal
   // and in other bases, digits above nine, and bases just outside the legal range.
   itoa_req_type directed_words [24] = '{
      {32'h8000_0000, 5'd2},    // most negative value, longest output
      {32'h8000_0000, 5'd10},   // most negative value with a sign
      {32'h7fff_ffff, 5'd2},
      {32'h7fff_ffff, 5'd10},
      {32'h0000_0000, 5'd10},   // zero gives a single '0'
      {32'h0000_0000, 5'd2},
      {32'hffff_ffff, 5'd10},
      {32'hffff_ffff, 5'd16},   // negative outside decimal prints the magnitude only
      {32'hffff_ffff, 5'd2},
      {32'hfedc_ba98, 5'd16},
      {32'h7fff_ffff, 5'd16},
      {32'h0abc_def0, 5'd16},   // every letter digit
      {32'h0000_000f, 5'd16},
      {32'h8000_0000, 5'd16},
      {32'h7fff_ffff, 5'd3},
      {32'h8000_0000, 5'd7},
      {32'd12345,     5'd8},
      {32'hffff_fff7, 5'd10},   // minus nine
      {32'd1000,      5'd15},
      {32'h5555_5555, 5'd5},
      {32'h8000_0000, 5'd0},    // bases outside 2..16 give one error word
      {32'h7fff_ffff, 5'd1},
      {32'h0000_0000, 5'd17},
      {32'hffff_ffff, 5'd31}
   };

   always #5 clock = ~clock;

   integer_to_radix_ascii_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   itoa_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_item      (req_item),
      .rsp_strobe    (rsp_strobe),
      .rsp_item      (rsp_item),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // The watchdog restarts whenever a word moves on either channel. A block that
   // hangs, or never returns owed characters, ends the run here.
   always @(posedge clock) begin
      if ((start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d quiet cycles", idle_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

   // Holds start high with the word until the block takes it. Start is left high so
   // that a following word can go out in the very next cycle without a glitch.
   task automatic send_word(input itoa_req_type word);
      req_item <= word;
      start <= 1'b1;
      words_sent++;
      if (word.radix < MIN_RADIX || word.radix > MAX_RADIX) begin
         bad_radix_sent++;
      end
      do begin
         @(posedge clock);
      end while (busy);
   endtask

   // Drops start for a burst of cycles. The payload carries noise meanwhile, which
   // the block must ignore since start is low.
   task automatic pause_sender(input int cycles);
      start <= 1'b0;
      repeat (cycles) begin
         req_item <= {$urandom(), 5'($urandom())};
         @(posedge clock);
      end
   endtask

   // Mixes full-range values with the corners where digit counts change: zero,
   // small values of either sign, powers of two and the two extremes.
   function automatic logic [VALUE_WIDTH-1:0] pick_number();
      logic [VALUE_WIDTH-1:0] value;
      case ($urandom_range(0, 9))
         0: value = ($urandom_range(0, 1) == 0) ? 32'h8000_0000 : 32'h7fff_ffff;
         1: value = ($urandom_range(0, 1) == 0) ? 32'h0000_0000 : 32'hffff_ffff;
         2: value = 32'($urandom_range(0, 40));
         3: value = -32'($urandom_range(1, 40));
         4: value = 32'h1 << $urandom_range(0, 31);
         5: value = (32'h1 << $urandom_range(0, 31)) - 1'b1;
         6: value = $urandom() >> $urandom_range(0, 31);
         default: value = $urandom();
      endcase
      return value;
   endfunction

   // Most words use a legal base so that conversions dominate the run.
   function automatic logic [RADIX_WIDTH-1:0] pick_radix();
      if ($urandom_range(0, 99) < 85) begin
         return RADIX_WIDTH'($urandom_range(MIN_RADIX, MAX_RADIX));
      end
      return RADIX_WIDTH'($urandom_range(0, 31));
   endfunction

   initial begin
      int gap_chance;
      itoa_req_type word;
      reset <= 1'b1;
      start <= 1'b0;
      req_item <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed words go out back to back.
      foreach (directed_words[i]) begin
         send_word(directed_words[i]);
      end

      // Random words. The chance of a sender gap changes every phase, so some
      // stretches run without gaps and others are full of them. The tail has none.
      gap_chance = 0;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % PHASE_LENGTH == 0) begin
            case ($urandom_range(0, 2))
               0: gap_chance = 0;
               1: gap_chance = 25;
               default: gap_chance = 60;
            endcase
         end
         if (n >= RANDOM_WORDS - STEADY_TAIL) begin
            gap_chance = 0;
         end
         if ($urandom_range(0, 99) < gap_chance) begin
            pause_sender($urandom_range(1, 17));
         end
         word.number = pick_number();
         word.radix = pick_radix();
         send_word(word);
      end
      start <= 1'b0;

      // Let every owed character arrive, then watch for stray words a while longer.
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d conversion words, %0d of them with a base outside 2..16.",
               words_sent, bad_radix_sent);
      $display("Compared %0d character words; %0d still owed at the end.",
               checked_count, pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
